FILE: src/texture_atlas_shelf_packer_macros.svh
// Assertion helpers for the shelf packer.
`ifndef TEXTURE_ATLAS_SHELF_PACKER_MACROS_SVH
`define TEXTURE_ATLAS_SHELF_PACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TASP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TASP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/tasp_pkg.sv
package tasp_pkg;

   localparam int DIM_BITS          = 12;
   localparam int POS_BITS          = 6;
   localparam int SHEET_W_BITS      = 12;
   localparam int INIT_H_BITS       = 17;
   localparam int Y_BITS            = 18;
   localparam int SHEET_H_BITS      = 20;
   localparam int CSR_IDX_BITS      = 1;
   localparam int CSR_DATA_BITS     = 17;
   localparam int MAX_RECTS_DEFAULT = 64;

   localparam logic [SHEET_W_BITS-1:0] INIT_W_RESET = 12'd256;
   localparam logic [INIT_H_BITS-1:0]  INIT_H_RESET = 17'd8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_HEIGHT = 1'd1;

   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic [DIM_BITS-1:0] w;
      logic [DIM_BITS-1:0] h;
   } rect_entry_type;

endpackage

FILE: src/tasp_ram.sv
module tasp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/texture_atlas_shelf_packer.sv
// Shelf packer for texture atlas rectangles.
// Input channel (req_*): one rectangle size per item; req_last_rect closes the set.
// Each rectangle is inserted into a height-sorted store (descending, ties in load
// order). Into an empty store it is written directly; otherwise each stored entry
// shorter than the new one is shifted up one slot before it is written, one entry
// moving per cycle through the store RAM's single read and write port.
// The item marked last starts packing; no item is accepted until the set is done.
// Result channel (rsp_*): one placement per stored rectangle, in sorted order.
// Each placement steps through a RAM read, the placement calculation, sheet height
// doubling until the rectangle fits, and output. rsp_last_placement marks the end.
// A held result sits in the output register; a stalled receiver holds packing
// at its next placement, while the next set may start loading once the final
// placement is registered.
// Items beyond MAX_RECTS are dropped and rsp_overflow is set for that set.
// Reset sets the CSR sheet size to 256 x 8 and empties the store; store entries
// are read only after being written, so the RAM needs no clearing pass.
// CSR writes (index 0 width, 1 height; 0 reads as 1) apply at the next packing.
`include "texture_atlas_shelf_packer_macros.svh"

module texture_atlas_shelf_packer
   import tasp_pkg::*;
#(
   parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DIM_BITS-1:0]      req_rect_width,
   input  logic [DIM_BITS-1:0]      req_rect_height,
   input  logic                     req_last_rect,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POS_BITS-1:0]      rsp_load_position,
   output logic [SHEET_W_BITS-1:0]  rsp_place_x,
   output logic [Y_BITS-1:0]        rsp_place_y,
   output logic [DIM_BITS-1:0]      rsp_placed_width,
   output logic [DIM_BITS-1:0]      rsp_placed_height,
   output logic [SHEET_W_BITS-1:0]  rsp_sheet_width,
   output logic [SHEET_H_BITS-1:0]  rsp_sheet_height,
   output logic                     rsp_overflow,
   output logic                     rsp_last_placement
);

   localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int ENT_W = $bits(rect_entry_type);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_INS     = 7'b0000010,
      S_PUT     = 7'b0000100,
      S_PK_RD   = 7'b0001000,
      S_PK_CALC = 7'b0010000,
      S_PK_GROW = 7'b0100000,
      S_PK_OUT  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   rect_entry_type          new_ent_ff, new_ent_in;
   logic                    last_ff, last_in;
   logic [IDX_W-1:0]        ins_idx_ff, ins_idx_in;
   logic [IDX_W-1:0]        pk_idx_ff, pk_idx_in;
   rect_entry_type          cur_ent_ff, cur_ent_in;
   logic [SHEET_W_BITS-1:0] cx_ff, cx_in;
   logic [Y_BITS-1:0]       cy_ff, cy_in;
   logic [DIM_BITS-1:0]     rowh_ff, rowh_in;
   logic [SHEET_W_BITS-1:0] sw_ff, sw_in;
   logic [SHEET_H_BITS-1:0] sh_ff, sh_in;
   logic [SHEET_W_BITS-1:0] init_w_ff;
   logic [INIT_H_BITS-1:0]  init_h_ff;
   logic                    rsp_valid_ff;

   logic [POS_BITS-1:0]     rsp_pos_ff;
   logic [SHEET_W_BITS-1:0] rsp_x_ff;
   logic [Y_BITS-1:0]       rsp_y_ff;
   logic [DIM_BITS-1:0]     rsp_w_ff;
   logic [DIM_BITS-1:0]     rsp_h_ff;
   logic [SHEET_W_BITS-1:0] rsp_sw_ff;
   logic [SHEET_H_BITS-1:0] rsp_sh_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_last_ff;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   rect_entry_type          ram_wdata;
   logic [IDX_W-1:0]        ram_raddr;
   logic [ENT_W-1:0]        ram_rdata;
   rect_entry_type          rd_ent;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    pk_last;
   logic                    start_pack;
   logic                    finish_ins;
   rect_entry_type          req_ent;
   logic                    wrap;
   logic [SHEET_W_BITS-1:0] cx1;
   logic [Y_BITS-1:0]       cy1;
   logic [DIM_BITS-1:0]     rowh1;
   logic [SHEET_H_BITS-1:0] need_h;

   tasp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_RECTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_ent     = ram_rdata;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign pk_last    = ((CNT_W'(pk_idx_ff) + CNT_W'(1)) == count_ff);
   assign req_ent    = '{pos: POS_BITS'(count_ff), w: req_rect_width, h: req_rect_height};

   // Row wrap and sheet widening for the entry just read.
   assign wrap  = (cx_ff != '0) &&
                  ((13'(cx_ff) + 13'(rd_ent.w)) > 13'(sw_ff));
   assign cx1   = wrap ? '0 : cx_ff;
   assign cy1   = wrap ? (cy_ff + Y_BITS'(rowh_ff)) : cy_ff;
   assign rowh1 = wrap ? '0 : rowh_ff;
   assign need_h = SHEET_H_BITS'(cy_ff) + SHEET_H_BITS'(cur_ent_ff.h);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      new_ent_in = new_ent_ff;
      last_in    = last_ff;
      ins_idx_in = ins_idx_ff;
      pk_idx_in  = pk_idx_ff;
      cur_ent_in = cur_ent_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rowh_in    = rowh_ff;
      sw_in      = sw_ff;
      sh_in      = sh_ff;
      ram_we     = 1'b0;
      ram_waddr  = ins_idx_ff;
      ram_wdata  = new_ent_ff;
      ram_raddr  = pk_idx_ff;
      rsp_load   = 1'b0;
      start_pack = 1'b0;
      finish_ins = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               new_ent_in = req_ent;
               last_in    = req_last_rect;
               if (count_ff == CNT_W'(MAX_RECTS)) begin
                  // drop the item, still pack on last
                  ovf_in     = 1'b1;
                  start_pack = req_last_rect;
               end else if (count_ff == '0) begin
                  ram_we     = 1'b1;
                  ram_waddr  = '0;
                  ram_wdata  = req_ent;
                  count_in   = count_ff + CNT_W'(1);
                  start_pack = req_last_rect;
               end else begin
                  ram_raddr  = IDX_W'(count_ff - CNT_W'(1));
                  ins_idx_in = IDX_W'(count_ff);
                  state_in   = S_INS;
               end
            end
         end
         S_INS: begin
            if (rd_ent.h < new_ent_ff.h) begin
               // shift the shorter entry up one slot
               ram_we     = 1'b1;
               ram_waddr  = ins_idx_ff;
               ram_wdata  = rd_ent;
               ins_idx_in = ins_idx_ff - IDX_W'(1);
               ram_raddr  = ins_idx_ff - IDX_W'(2);
               if (ins_idx_ff == IDX_W'(1)) begin
                  state_in = S_PUT;
               end
            end else begin
               ram_we     = 1'b1;
               ram_waddr  = ins_idx_ff;
               finish_ins = 1'b1;
            end
         end
         S_PUT: begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            finish_ins = 1'b1;
         end
         S_PK_RD: begin
            ram_raddr = pk_idx_ff;
            state_in  = S_PK_CALC;
         end
         S_PK_CALC: begin
            cur_ent_in = rd_ent;
            cx_in      = cx1;
            cy_in      = cy1;
            rowh_in    = (rd_ent.h > rowh1) ? rd_ent.h : rowh1;
            if ((cx1 == '0) && (rd_ent.w > sw_ff)) begin
               sw_in = rd_ent.w;
            end
            state_in = S_PK_GROW;
         end
         S_PK_GROW: begin
            if (need_h > sh_ff) begin
               sh_in = {sh_ff[SHEET_H_BITS-2:0], 1'b0};
            end else begin
               state_in = S_PK_OUT;
            end
         end
         S_PK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               cx_in    = cx_ff + cur_ent_ff.w;
               if (pk_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  pk_idx_in = pk_idx_ff + IDX_W'(1);
                  state_in  = S_PK_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish_ins) begin
         count_in   = count_ff + CNT_W'(1);
         state_in   = S_IDLE;
         start_pack = last_ff;
      end

      if (start_pack) begin
         pk_idx_in = '0;
         cx_in     = '0;
         cy_in     = '0;
         rowh_in   = '0;
         sw_in     = (init_w_ff == '0) ? SHEET_W_BITS'(1) : init_w_ff;
         sh_in     = (init_h_ff == '0) ? SHEET_H_BITS'(1) : SHEET_H_BITS'(init_h_ff);
         state_in  = S_PK_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         init_w_ff    <= INIT_W_RESET;
         init_h_ff    <= INIT_H_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (csr_wr_en && (csr_index == CSR_INIT_WIDTH)) begin
            init_w_ff <= csr_wdata[SHEET_W_BITS-1:0];
         end
         if (csr_wr_en && (csr_index == CSR_INIT_HEIGHT)) begin
            init_h_ff <= csr_wdata[INIT_H_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      new_ent_ff <= new_ent_in;
      last_ff    <= last_in;
      ins_idx_ff <= ins_idx_in;
      pk_idx_ff  <= pk_idx_in;
      cur_ent_ff <= cur_ent_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      rowh_ff    <= rowh_in;
      sw_ff      <= sw_in;
      sh_ff      <= sh_in;
      if (rsp_load) begin
         rsp_pos_ff  <= cur_ent_ff.pos;
         rsp_x_ff    <= cx_ff;
         rsp_y_ff    <= cy_ff;
         rsp_w_ff    <= cur_ent_ff.w;
         rsp_h_ff    <= cur_ent_ff.h;
         rsp_sw_ff   <= sw_ff;
         rsp_sh_ff   <= sh_ff;
         rsp_ovf_ff  <= ovf_ff;
         rsp_last_ff <= pk_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_load_position  = rsp_pos_ff;
   assign rsp_place_x        = rsp_x_ff;
   assign rsp_place_y        = rsp_y_ff;
   assign rsp_placed_width   = rsp_w_ff;
   assign rsp_placed_height  = rsp_h_ff;
   assign rsp_sheet_width    = rsp_sw_ff;
   assign rsp_sheet_height   = rsp_sh_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last_placement = rsp_last_ff;

   `TASP_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_RECTS), "rect count exceeds store depth")
   `TASP_ASSERT_SAME(a_ins_idx, clock, reset, state_ff == S_INS, ins_idx_ff != '0, "insertion walked below slot zero")
   `TASP_ASSERT_SAME(a_fit_width, clock, reset, state_ff == S_PK_OUT, (13'(cx_ff) + 13'(cur_ent_ff.w)) <= 13'(sw_ff), "placement exceeds sheet width")
   `TASP_ASSERT_SAME(a_fit_height, clock, reset, state_ff == S_PK_OUT, need_h <= sh_ff, "placement exceeds sheet height")
   `TASP_ASSERT_NEXT(a_set_end, clock, reset, rsp_load && pk_last, (state_ff == S_IDLE) && (count_ff == '0) && rsp_valid_ff, "set not cleared after final placement")

endmodule
